// ===== design/smooth_vertex_normal_engine_unit_macros.svh =====
// assertion helpers, compiled out for synthesis
`ifndef SMOOTH_VERTEX_NORMAL_ENGINE_UNIT_MACROS_SVH
`define SMOOTH_VERTEX_NORMAL_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SVN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SVN_ASSERT_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
`else
`define SVN_ASSERT(lbl, prop, msg)
`define SVN_ASSERT_IMPLY(lbl, pre, post, msg)
`endif
`endif

// ===== design/svn_pkg.sv =====
package svn_pkg;

  localparam int POS_W  = 20;
  localparam int IDX_W  = 10;
  localparam int SLOT_W = 16;
  localparam int SUM_W  = 56;
  localparam int NRM_W  = 16;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_RANGE = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_TRI   = 2'd2,
    FUNC_READ  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_REPORT = 2'd0,
    KIND_LOAD   = 2'd1,
    KIND_TRI    = 2'd2,
    KIND_READ   = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [1:0]         status;
    logic [SLOT_W-1:0]  slot;
    logic [IDX_W-1:0]   idx_a;
    logic [IDX_W-1:0]   idx_b;
    logic [IDX_W-1:0]   idx_c;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [POS_W-1:0]   pos_z;
  } cmd_t;

endpackage

// ===== design/svn_ram.sv =====
module svn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/svn_front.sv =====
`include "smooth_vertex_normal_engine_unit_macros.svh"

module svn_front #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [95:0]   s_axis_tdata,
  input  logic [1:0]    s_axis_tuser,
  input  logic          full_i,
  output logic          push_o,
  output svn_pkg::cmd_t cmd_o
);
  import svn_pkg::*;

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  logic [CW-1:0] count_q, count_d;
  logic          accept;
  logic          bad_a, bad_b, bad_c, is_full;
  logic [IDX_W-1:0] idx_a, idx_b, idx_c;
  func_e         func;
  cmd_t          cmd;

  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && !full_i;
  assign push_o        = accept;
  assign cmd_o         = cmd;

  assign func  = func_e'(s_axis_tuser);
  assign idx_a = s_axis_tdata[69:60];
  assign idx_b = s_axis_tdata[79:70];
  assign idx_c = s_axis_tdata[89:80];

  assign bad_a   = XW'(idx_a) >= XW'(count_q);
  assign bad_b   = XW'(idx_b) >= XW'(count_q);
  assign bad_c   = XW'(idx_c) >= XW'(count_q);
  assign is_full = count_q == CW'(MAX_VERTICES);

  always_comb begin
    count_d    = count_q;
    cmd.kind   = KIND_REPORT;
    cmd.status = STATUS_OK;
    cmd.slot   = SLOT_W'(count_q);
    cmd.idx_a  = idx_a;
    cmd.idx_b  = idx_b;
    cmd.idx_c  = idx_c;
    cmd.pos_x  = s_axis_tdata[19:0];
    cmd.pos_y  = s_axis_tdata[39:20];
    cmd.pos_z  = s_axis_tdata[59:40];
    case (func)
      FUNC_CLEAR: begin
        count_d = '0;
      end
      FUNC_LOAD: begin
        if (is_full) begin
          cmd.status = STATUS_FULL;
        end else begin
          cmd.kind = KIND_LOAD;
          count_d  = count_q + CW'(1);
        end
      end
      FUNC_TRI: begin
        if (bad_a || bad_b || bad_c) begin
          cmd.status = STATUS_RANGE;
        end else begin
          cmd.kind = KIND_TRI;
        end
      end
      FUNC_READ: begin
        if (bad_a) begin
          cmd.status = STATUS_RANGE;
        end else begin
          cmd.kind = KIND_READ;
        end
      end
      default: begin
        count_d = count_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  `SVN_ASSERT(a_count_bound, count_q <= CW'(MAX_VERTICES), "vertex count beyond store size")

endmodule

// ===== design/svn_fifo.sv =====
`include "smooth_vertex_normal_engine_unit_macros.svh"

module svn_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  svn_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output svn_pkg::cmd_t cmd_o,
  output logic          empty_o
);
  import svn_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign cmd_o   = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wp_q <= !wp_q;
      end
      if (pop_i) begin
        rp_q <= !rp_q;
      end
    end
  end

  `SVN_ASSERT(a_fifo_bound, cnt_q != 2'd3, "command queue overflow")
  `SVN_ASSERT_IMPLY(a_fifo_pop, pop_i, !empty_o, "pop from empty command queue")

endmodule

// ===== design/svn_back.sv =====
`include "smooth_vertex_normal_engine_unit_macros.svh"

module svn_back #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  svn_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [47:0]   m_axis_tdata,
  output logic [1:0]    m_axis_tuser
);
  import svn_pkg::*;

  localparam int AW    = $clog2(MAX_VERTICES);
  localparam int POS_ROW_W = 3 * POS_W;
  localparam int SUM_ROW_W = 3 * SUM_W;
  localparam int D_W   = POS_W + 1;
  localparam int F_W   = 2 * D_W + 1;
  localparam int HALF_W = SUM_W / 2;
  localparam int MUL_W = HALF_W + 1;
  localparam int SQ_W  = 2 * SUM_W;
  localparam logic [SUM_W-1:0] SUM_LIMIT = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W:0] SAT_HI = {1'b0, SUM_LIMIT};
  localparam logic signed [SUM_W:0] SAT_LO = -SAT_HI;
  localparam logic [NRM_W-2:0] ONE_Q14 = 15'd16384;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_TRD  = 11'b00000000010,
    S_TMUL = 11'b00000000100,
    S_TRMW = 11'b00000001000,
    S_RRD  = 11'b00000010000,
    S_RCAP = 11'b00000100000,
    S_SQ   = 11'b00001000000,
    S_CHK  = 11'b00010000000,
    S_SQRT = 11'b00100000000,
    S_DIV  = 11'b01000000000,
    S_FIN  = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd_q, cmd_d;
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] comp_q, comp_d;
  logic [2:0] sel_q;

  logic [POS_ROW_W-1:0] rows_q [3];
  logic [POS_ROW_W-1:0] rows_d [3];
  logic signed [F_W-1:0] f_q [3];
  logic signed [F_W-1:0] f_d [3];
  logic [SUM_W-1:0] mag_q [3];
  logic [SUM_W-1:0] mag_d [3];
  logic [2:0] sgn_q, sgn_d;
  logic [SQ_W-1:0] acc_q, acc_d;
  logic [SUM_W+2:0] rem_q, rem_d;
  logic [SUM_W-1:0] root_q, root_d;
  logic [NRM_W-2:0] quo_q, quo_d;
  logic [NRM_W-1:0] nrm_q [3];
  logic [NRM_W-1:0] nrm_d [3];
  logic [1:0] status_q, status_d;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [2*MUL_W-1:0] prod_q;

  logic [47:0] out_data_q;
  logic [1:0]  out_user_q;
  logic        out_valid_q, out_load;

  logic                 pos_we, sum_we;
  logic [AW-1:0]        pos_waddr, sum_waddr, pos_raddr, sum_raddr;
  logic [POS_ROW_W-1:0] pos_wdata, pos_rdata;
  logic [SUM_ROW_W-1:0] sum_wdata, sum_rdata;

  logic signed [D_W-1:0] ux, uy, uz, vx, vy, vz;
  logic [1:0] k_rd, k_rmw;
  logic [SUM_W+2:0] rem_sh, trial;
  logic [SUM_W:0] div_r, div_l, div_sub;
  logic div_ge;
  logic [NRM_W-2:0] quo_new, quo_clamp;
  logic [SQ_W-1:0] pp;

  function automatic logic [AW-1:0] corner(input cmd_t c, input logic [1:0] k);
    logic [IDX_W-1:0] idx;
    case (k)
      2'd0:    idx = c.idx_a;
      2'd1:    idx = c.idx_b;
      default: idx = c.idx_c;
    endcase
    return AW'(idx);
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                               input logic [F_W-1:0] f);
    logic signed [SUM_W:0] t;
    t = $signed({s[SUM_W-1], s}) + $signed({{(SUM_W+1-F_W){f[F_W-1]}}, f});
    if (t > SAT_HI) begin
      t = SAT_HI;
    end else if (t < SAT_LO) begin
      t = SAT_LO;
    end
    return t[SUM_W-1:0];
  endfunction

  function automatic logic signed [D_W-1:0] pdiff(input logic [POS_W-1:0] p,
                                                  input logic [POS_W-1:0] q);
    return $signed({p[POS_W-1], p}) - $signed({q[POS_W-1], q});
  endfunction

  svn_ram #(.WIDTH(POS_ROW_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  svn_ram #(.WIDTH(SUM_ROW_W), .DEPTH(MAX_VERTICES)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (sum_raddr),
    .rdata_o (sum_rdata)
  );

  assign ux = pdiff(rows_q[1][POS_W-1:0],         rows_q[0][POS_W-1:0]);
  assign uy = pdiff(rows_q[1][2*POS_W-1:POS_W],   rows_q[0][2*POS_W-1:POS_W]);
  assign uz = pdiff(rows_q[1][3*POS_W-1:2*POS_W], rows_q[0][3*POS_W-1:2*POS_W]);
  assign vx = pdiff(rows_q[2][POS_W-1:0],         rows_q[0][POS_W-1:0]);
  assign vy = pdiff(rows_q[2][2*POS_W-1:POS_W],   rows_q[0][2*POS_W-1:POS_W]);
  assign vz = pdiff(rows_q[2][3*POS_W-1:2*POS_W], rows_q[0][3*POS_W-1:2*POS_W]);

  assign k_rd  = cnt_q[1:0];
  assign k_rmw = cnt_q[2:1];

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_TMUL) begin
      case (cnt_q[2:0])
        3'd0:    begin mul_a = MUL_W'(uy); mul_b = MUL_W'(vz); end
        3'd1:    begin mul_a = MUL_W'(uz); mul_b = MUL_W'(vy); end
        3'd2:    begin mul_a = MUL_W'(uz); mul_b = MUL_W'(vx); end
        3'd3:    begin mul_a = MUL_W'(ux); mul_b = MUL_W'(vz); end
        3'd4:    begin mul_a = MUL_W'(ux); mul_b = MUL_W'(vy); end
        3'd5:    begin mul_a = MUL_W'(uy); mul_b = MUL_W'(vx); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (state_q == S_SQ) begin
      mul_a = $signed({1'b0, cnt_q[1] ? mag_q[cnt_q[3:2]][SUM_W-1:HALF_W]
                                      : mag_q[cnt_q[3:2]][HALF_W-1:0]});
      mul_b = $signed({1'b0, cnt_q[0] ? mag_q[cnt_q[3:2]][SUM_W-1:HALF_W]
                                      : mag_q[cnt_q[3:2]][HALF_W-1:0]});
    end
  end

  always_comb begin
    case (sel_q[1:0])
      2'd0:    pp = SQ_W'(prod_q[2*HALF_W-1:0]);
      2'd3:    pp = SQ_W'(prod_q[2*HALF_W-1:0]) << (2 * HALF_W);
      default: pp = SQ_W'(prod_q[2*HALF_W-1:0]) << HALF_W;
    endcase
  end

  assign rem_sh  = {rem_q[SUM_W:0], acc_q[SQ_W-1:SQ_W-2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign div_r   = rem_q[SUM_W:0];
  assign div_l   = {1'b0, root_q};
  assign div_ge  = div_r >= div_l;
  assign div_sub = div_ge ? div_r - div_l : div_r;
  assign quo_new = {quo_q[NRM_W-3:0], div_ge};
  assign quo_clamp = (quo_new > ONE_Q14) ? ONE_Q14 : quo_new;

  assign pop_o    = (state_q == S_IDLE) && !empty_i;
  assign out_load = (state_q == S_FIN) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    cnt_d    = cnt_q;
    comp_d   = comp_q;
    rows_d   = rows_q;
    f_d      = f_q;
    mag_d    = mag_q;
    sgn_d    = sgn_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    root_d   = root_q;
    quo_d    = quo_q;
    nrm_d    = nrm_q;
    status_d = status_q;
    pos_we    = 1'b0;
    sum_we    = 1'b0;
    pos_waddr = AW'(cmd_i.slot);
    sum_waddr = AW'(cmd_i.slot);
    pos_wdata = {cmd_i.pos_z, cmd_i.pos_y, cmd_i.pos_x};
    sum_wdata = '0;
    pos_raddr = corner(cmd_q, k_rd);
    sum_raddr = corner(cmd_q, k_rmw);
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          cmd_d    = cmd_i;
          status_d = cmd_i.status;
          nrm_d[0] = '0;
          nrm_d[1] = '0;
          nrm_d[2] = '0;
          cnt_d    = '0;
          case (cmd_i.kind)
            KIND_LOAD: begin
              pos_we  = 1'b1;
              sum_we  = 1'b1;
              state_d = S_FIN;
            end
            KIND_TRI:  state_d = S_TRD;
            KIND_READ: state_d = S_RRD;
            default:   state_d = S_FIN;
          endcase
        end
      end
      S_TRD: begin
        if (cnt_q != 6'd0) begin
          rows_d[k_rd - 2'd1] = pos_rdata;
        end
        if (cnt_q == 6'd3) begin
          cnt_d   = '0;
          f_d[0]  = '0;
          f_d[1]  = '0;
          f_d[2]  = '0;
          state_d = S_TMUL;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_TMUL: begin
        if (cnt_q != 6'd0) begin
          if (sel_q[0]) begin
            f_d[sel_q[2:1]] = f_q[sel_q[2:1]] - F_W'($signed(prod_q[2*D_W-1:0]));
          end else begin
            f_d[sel_q[2:1]] = f_q[sel_q[2:1]] + F_W'($signed(prod_q[2*D_W-1:0]));
          end
        end
        if (cnt_q == 6'd6) begin
          cnt_d   = '0;
          state_d = S_TRMW;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_TRMW: begin
        if (cnt_q[0]) begin
          sum_we    = 1'b1;
          sum_waddr = corner(cmd_q, k_rmw);
          sum_wdata = {sat_add(sum_rdata[3*SUM_W-1:2*SUM_W], f_q[2]),
                       sat_add(sum_rdata[2*SUM_W-1:SUM_W],   f_q[1]),
                       sat_add(sum_rdata[SUM_W-1:0],         f_q[0])};
        end
        if (cnt_q == 6'd5) begin
          state_d = S_FIN;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_RRD: begin
        sum_raddr = AW'(cmd_q.idx_a);
        state_d   = S_RCAP;
      end
      S_RCAP: begin
        for (int i = 0; i < 3; i++) begin
          sgn_d[i] = sum_rdata[(i+1)*SUM_W-1];
          mag_d[i] = sgn_d[i] ? SUM_W'(0) - sum_rdata[i*SUM_W +: SUM_W]
                              : sum_rdata[i*SUM_W +: SUM_W];
        end
        acc_d   = '0;
        cnt_d   = '0;
        state_d = S_SQ;
      end
      S_SQ: begin
        if (cnt_q != 6'd0) begin
          acc_d = acc_q + pp;
        end
        if (cnt_q == 6'd12) begin
          state_d = S_CHK;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_CHK: begin
        rem_d  = '0;
        root_d = '0;
        cnt_d  = '0;
        if (acc_q <= SQ_W'(1)) begin
          nrm_d[1] = {1'b0, ONE_Q14};
          state_d  = S_FIN;
        end else begin
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        acc_d = acc_q << 2;
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[SUM_W-2:0], 1'b0};
        end
        if (cnt_q == 6'd55) begin
          cnt_d   = '0;
          comp_d  = 2'd0;
          quo_d   = '0;
          rem_d   = (SUM_W+3)'(mag_q[0]);
          state_d = S_DIV;
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_DIV: begin
        rem_d = (SUM_W+3)'({div_sub[SUM_W-1:0], 1'b0});
        quo_d = quo_new;
        if (cnt_q == 6'd14) begin
          nrm_d[comp_q] = sgn_q[comp_q] ? NRM_W'(0) - {1'b0, quo_clamp}
                                        : {1'b0, quo_clamp};
          cnt_d = '0;
          quo_d = '0;
          if (comp_q == 2'd2) begin
            state_d = S_FIN;
          end else begin
            comp_d = comp_q + 2'd1;
            rem_d  = (SUM_W+3)'(mag_q[comp_q + 2'd1]);
          end
        end else begin
          cnt_d = cnt_q + 6'd1;
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    cnt_q    <= cnt_d;
    comp_q   <= comp_d;
    sel_q    <= cnt_q[2:0];
    rows_q   <= rows_d;
    f_q      <= f_d;
    mag_q    <= mag_d;
    sgn_q    <= sgn_d;
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
    quo_q    <= quo_d;
    nrm_q    <= nrm_d;
    status_q <= status_d;
    prod_q   <= mul_a * mul_b;
    if (out_load) begin
      out_data_q <= {nrm_q[2], nrm_q[1], nrm_q[0]};
      out_user_q <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `SVN_ASSERT_IMPLY(a_div_len, state_q == S_DIV, root_q != '0, "zero length in divide")
  `SVN_ASSERT_IMPLY(a_div_rem, state_q == S_DIV, div_r < ((SUM_W+1)'(root_q) << 1), "divide remainder out of range")

endmodule

// ===== design/smooth_vertex_normal_engine_unit.sv =====
// channel   dir  tdata                                          tuser
// s_axis    in   pos_x, pos_y, pos_z, vertex_a, vertex_b, vertex_c func
// m_axis    out  normal_x, normal_y, normal_z                   status
// clear, load and rejected items go straight to the final state in the back;
// a triangle: 3 position reads, 6 products on one shared multiplier, 3 sum updates;
// a read: 12 partial squares, 56 square root steps, 3 x 15 divide steps
// the front and back are parted by a two-entry command queue; the back does one item
// at a time and holds its result until the output register is free
// no clearing pass after reset: stores are written before they are read
module smooth_vertex_normal_engine_unit #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pos_x, pos_y, pos_z, vertex_a, vertex_b, vertex_c, zero pad
  input  logic [95:0] s_axis_tdata,
  // func
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic [47:0] m_axis_tdata,
  // status
  output logic [1:0]  m_axis_tuser
);
  import svn_pkg::*;

  cmd_t front_cmd, queue_cmd;
  logic push, pop, full, empty;

  svn_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  svn_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (queue_cmd),
    .empty_o (empty)
  );

  svn_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .cmd_i         (queue_cmd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
